/* sv/upi_pkg.sv */
package upi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  localparam int XY_W = 36;
  localparam int Z_W  = 34;

  localparam logic [29:0] GAIN_INV     = 30'd652032874;
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

  typedef struct packed {
    logic load;
    logic vector_mode;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx, input int angle_bits);
    logic [31:0] t;
    logic [31:0] mask;
    case (idx)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    mask = 32'hFFFF_FFFF << (32 - angle_bits);
    return t & mask;
  endfunction

endpackage

/* sv/upi_cordic.sv */
module upi_cordic #(
  parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = upi_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  upi_pkg::cordic_ctl_t              ctl,
  input  logic signed [upi_pkg::XY_W-1:0]   x0,
  input  logic signed [upi_pkg::XY_W-1:0]   y0,
  input  logic signed [upi_pkg::Z_W-1:0]    z0,
  output logic signed [upi_pkg::XY_W-1:0]   x,
  output logic signed [upi_pkg::XY_W-1:0]   y,
  output logic signed [upi_pkg::Z_W-1:0]    z,
  output logic                              done
);
  import upi_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic [IW-1:0] i;
  logic          busy;
  logic          mode;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  t;
  logic                   dir;

  always_comb begin
    dx  = y >>> i;
    dy  = x >>> i;
    t   = Z_W'(atan_entry(5'(i), ANGLE_BITS));
    dir = mode ? y[XY_W-1] : ~z[Z_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.load) begin
        x    <= x0;
        y    <= y0;
        z    <= z0;
        mode <= ctl.vector_mode;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (dir) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - t;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + t;
        end
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

endmodule

/* sv/unicycle_pose_integrator_top.sv */
// a new item is taken only in S_IDLE, once the last result is out; the pace is set by the shared cordic
// unit run twice per item and the single shared multiplier used seven times
// the first item after reset only loads the start pose and gives no result
// reset: synchronous, active high; pose, started, state, out_valid and config regs
module unicycle_pose_integrator_top #(
  parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = upi_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] linear_velocity,
  input  logic signed [23:0] angular_velocity,
  input  logic [23:0]        elapsed_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [15:0]        pose_heading,
  output logic signed [31:0] lateral_error,
  output logic signed [15:0] heading_error
);
  import upi_pkg::*;

  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_START_X = 3'd1;
  localparam logic [2:0] REG_START_Y = 3'd2;
  localparam logic [2:0] REG_START_H = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_MV, S_MW, S_MA, S_MB, S_HD, S_CS, S_MC, S_MS, S_PY, S_PO, S_ML, S_FIN
  } state_t;

  state_t state;

  logic [30:0]        radius;
  logic signed [31:0] start_x, start_y;
  logic [15:0]        start_h;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0]        heading;
  logic               started;

  logic signed [23:0] v_r, w_r;
  logic [23:0]        dt_r;
  logic [31:0]        dist_mag;
  logic               dist_neg;
  logic [23:0]        m_lo;
  logic               w_neg;
  logic [53:0]        acc;
  logic [15:0]        hnext;
  logic               flip;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;

  cordic_ctl_t            cctl;
  logic signed [XY_W-1:0] cx0, cy0, cx, cy;
  logic signed [Z_W-1:0]  cz0, cz;
  logic                   cdone;

  upi_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl), .x0(cx0), .y0(cy0), .z0(cz0),
    .x(cx), .y(cy), .z(cz), .done(cdone)
  );

  function automatic logic signed [31:0] sat32(input logic signed [XY_W-1:0] a);
    if (a > XY_W'(signed'(32'sh7FFF_FFFF))) return 32'sh7FFF_FFFF;
    if (a < XY_W'(signed'(32'sh8000_0000))) return 32'sh8000_0000;
    return a[31:0];
  endfunction

  logic [23:0]            v_mag, w_mag;
  logic signed [XY_W-1:0] c_val, s_val, c_abs, s_abs;
  logic [33:0]            dmag;
  logic signed [XY_W-1:0] dval;
  logic signed [31:0]     new_x, new_y;
  logic [54:0]            hsum;
  logic [15:0]            delta;
  logic [31:0]            u_ang;
  logic                   u_flip;
  logic [33:0]            len;
  logic signed [XY_W-1:0] lat_full;
  logic [31:0]            ang, herr, herr_r;

  always_comb begin
    v_mag = v_r[23] ? 24'(-v_r) : v_r;
    w_mag = w_r[23] ? 24'(-w_r) : w_r;
    c_val = flip ? -cx : cx;
    s_val = flip ? -cy : cy;
    c_abs = c_val[XY_W-1] ? -c_val : c_val;
    s_abs = s_val[XY_W-1] ? -s_val : s_val;
    dmag  = 34'((prod[63:0] + 64'(1) * (64'd1 << 29)) >> 30);
    if (state == S_MS) dval = (dist_neg ^ c_val[XY_W-1]) ? -XY_W'(dmag) : XY_W'(dmag);
    else               dval = (dist_neg ^ s_val[XY_W-1]) ? -XY_W'(dmag) : XY_W'(dmag);
    new_x = sat32(XY_W'(pos_x) + dval);
    new_y = sat32(XY_W'(pos_y) + dval);
    hsum  = 55'(acc) + 55'((prod[53:0] + (54'd1 << 47)) >> 24);
    delta = hsum[39:24];
    u_ang  = {heading, 16'h0};
    u_flip = (u_ang[31:30] == 2'd1) || (u_ang[31:30] == 2'd2);
    len      = 34'((prod[63:0] + (64'd1 << 29)) >> 30);
    lat_full = XY_W'(len) - XY_W'(radius);
    ang    = (pos_x == 32'sd0 && pos_y == 32'sd0) ? 32'd0 : cz[31:0];
    herr   = ang + 32'h4000_0000 - {heading, 16'h0};
    herr_r = herr + 32'h0000_8000;

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MV: begin mul_a = 34'(v_mag); mul_b = 32'(dt_r); end
      S_MW: begin mul_a = 34'(w_mag); mul_b = 32'(dt_r); end
      S_MA: begin mul_a = 34'(prod[47:24]); mul_b = 32'(TURN_PER_RAD); end
      S_MB: begin mul_a = 34'(m_lo); mul_b = 32'(TURN_PER_RAD); end
      S_MC: begin mul_a = 34'(dist_mag); mul_b = c_abs[31:0]; end
      S_MS: begin mul_a = 34'(dist_mag); mul_b = s_abs[31:0]; end
      S_ML, S_FIN: begin mul_a = cx[33:0]; mul_b = 32'(GAIN_INV); end
      default: ;
    endcase

    cctl = '0;
    cx0  = XY_W'(GAIN_INV);
    cy0  = '0;
    cz0  = Z_W'(signed'(u_flip ? (u_ang - 32'h8000_0000) : u_ang));
    case (state)
      S_HD: cctl.load = 1'b1;
      S_PY: begin
        cctl.load        = 1'b1;
        cctl.vector_mode = 1'b1;
        if (pos_x[31]) begin
          cx0 = -XY_W'(pos_x);
          cy0 = -XY_W'(new_y);
          cz0 = Z_W'(34'sh0_8000_0000);
        end else begin
          cx0 = XY_W'(pos_x);
          cy0 = XY_W'(new_y);
          cz0 = '0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      radius    <= 31'd65536;
      start_x   <= '0;
      start_y   <= '0;
      start_h   <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_RADIUS:  radius  <= cfg_data[30:0];
          REG_START_X: start_x <= cfg_data;
          REG_START_Y: start_y <= cfg_data;
          REG_START_H: start_h <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!started) begin
              pos_x   <= start_x;
              pos_y   <= start_y;
              heading <= start_h;
              started <= 1'b1;
            end else begin
              v_r   <= linear_velocity;
              w_r   <= angular_velocity;
              dt_r  <= elapsed_time;
              state <= S_MV;
            end
          end
        end
        S_MV: state <= S_MW;
        S_MW: begin
          dist_mag <= 32'((prod[47:0] + 48'h8000) >> 16);
          dist_neg <= v_r[23];
          w_neg    <= w_r[23];
          state    <= S_MA;
        end
        S_MA: begin
          m_lo  <= prod[23:0];
          state <= S_MB;
        end
        S_MB: begin
          acc   <= prod[53:0];
          state <= S_HD;
        end
        S_HD: begin
          hnext <= w_neg ? heading - delta : heading + delta;
          flip  <= u_flip;
          state <= S_CS;
        end
        S_CS: if (cdone) state <= S_MC;
        S_MC: state <= S_MS;
        S_MS: begin
          pos_x <= new_x;
          state <= S_PY;
        end
        S_PY: begin
          pos_y   <= new_y;
          heading <= hnext;
          state   <= S_PO;
        end
        S_PO: if (cdone) state <= S_ML;
        S_ML: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            pose_x        <= pos_x;
            pose_y        <= pos_y;
            pose_heading  <= heading;
            lateral_error <= sat32(lat_full);
            heading_error <= herr_r[31:16];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import upi_pkg::*;

  localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS_DEF + 30;
  localparam int RANDOM_ITEMS = 950;

  localparam logic [2:0] REG_RADIUS  = 3'd0;
  localparam logic [2:0] REG_START_X = 3'd1;
  localparam logic [2:0] REG_START_Y = 3'd2;
  localparam logic [2:0] REG_START_H = 3'd3;

  localparam longint GAIN_INV_C = 652032874;
  localparam longint unsigned RAD_TO_TURN = 64'd683565276;
  localparam logic [31:0] ARCTAN_TURN [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };
  localparam logic [31:0] ARCTAN_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS_DEF);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
    logic signed [31:0] lat;
    logic signed [15:0] herr;
  } pose_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] linear_velocity;
  logic signed [23:0] angular_velocity;
  logic [23:0]        elapsed_time;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic signed [31:0] lateral_error;
  logic signed [15:0] heading_error;

  unicycle_pose_integrator_top DUT (.*);

  // predictor state
  logic [30:0] radius_reg;
  longint      start_x_reg;
  longint      start_y_reg;
  logic [15:0] start_hdg_reg;
  longint      robot_x;
  longint      robot_y;
  logic [15:0] robot_hdg;
  bit          pose_loaded;

  pose_t pending_poses[$];
  int    errors;
  int    burst_left;
  bit    gaps_on;
  int    stall_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[unicycle_pose_integrator_top] ERROR");
    $finish;
  end

  function automatic longint round_div(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    return longint'({32'd0, ARCTAN_TURN[i] & ARCTAN_MASK});
  endfunction

  task automatic rotate_heading(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] u;
    bit          flip;
    longint      x, y, z, dx, dy;
    u = {ang, 16'd0};
    flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
    if (flip) u = u - 32'h8000_0000;
    z = longint'($signed(u));
    x = GAIN_INV_C;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic to_polar(input longint px, input longint py,
                          output logic [31:0] ang, output longint len);
    longint x, y, z, dx, dy;
    x = px; y = py; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    ang = (px == 0 && py == 0) ? 32'd0 : z[31:0];
    len = round_div(x * GAIN_INV_C, 30);
  endtask

  task automatic integrate_command(input logic signed [23:0] v, input logic signed [23:0] w,
                                   input logic [23:0] dt);
    longint             travel, c, s, p, len;
    longint unsigned    m, hi, lo, delta, herr;
    logic [31:0]        ang;
    pose_t              exp_pose;
    if (!pose_loaded) begin
      robot_x = start_x_reg;
      robot_y = start_y_reg;
      robot_hdg = start_hdg_reg;
      pose_loaded = 1'b1;
      return;
    end
    travel = round_div(longint'(v) * longint'({40'd0, dt}), 16);
    rotate_heading(robot_hdg, c, s);
    robot_x = clamp32(robot_x + round_div(travel * c, 30));
    robot_y = clamp32(robot_y + round_div(travel * s, 30));
    p = longint'(w) * longint'({40'd0, dt});
    m = (p < 0) ? longint'(-p) : p;
    hi = m >> 24;
    lo = m & 64'hFF_FFFF;
    delta = (hi * RAD_TO_TURN + ((lo * RAD_TO_TURN + (64'd1 << 47)) >> 24)) >> 24;
    if (p < 0) robot_hdg = robot_hdg - delta[15:0];
    else robot_hdg = robot_hdg + delta[15:0];
    to_polar(robot_x, robot_y, ang, len);
    herr = {32'd0, ang + 32'h4000_0000 - {robot_hdg, 16'd0}};
    herr = (herr + 64'h8000) >> 16;
    exp_pose.x = robot_x[31:0];
    exp_pose.y = robot_y[31:0];
    exp_pose.hdg = robot_hdg;
    exp_pose.lat = 32'(clamp32(len - longint'({33'd0, radius_reg})));
    exp_pose.herr = herr[15:0];
    pending_poses.push_back(exp_pose);
  endtask

  task automatic send_command(input logic signed [23:0] v, input logic signed [23:0] w,
                              input logic [23:0] dt);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    linear_velocity = v;
    angular_velocity = w;
    elapsed_time = dt;
    do @(posedge clk); while (!in_ready);
    integrate_command(v, w, dt);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RADIUS:  radius_reg = data[30:0];
      REG_START_X: start_x_reg = longint'($signed(data));
      REG_START_Y: start_y_reg = longint'($signed(data));
      REG_START_H: start_hdg_reg = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_command();
    logic signed [23:0] v, w;
    logic [23:0]        dt;
    v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 262143)) - 131072);
    w = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 524287)) - 262144);
    case ($urandom_range(0, 7))
      0: dt = 24'($urandom);
      1: dt = 24'd0;
      default: dt = 24'($urandom_range(0, 16383));
    endcase
    send_command(v, w, dt);
  endtask

  // receiver
  initial begin
    int mode_left;
    bit busy_mode;
    out_ready = 1'b0;
    mode_left = 0;
    busy_mode = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        busy_mode = 1'($urandom_range(0, 1));
      end
      mode_left--;
      if (stall_hold > 0) begin
        stall_hold--;
        out_ready = 1'b0;
      end else if (busy_mode) begin
        out_ready = ($urandom_range(0, 2) != 0);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d", $time, pose_x, pose_y);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        if (pose_x !== e.x) begin
          $display("%0t pose_x exp %0d got %0d", $time, e.x, pose_x);
          errors++;
        end
        if (pose_y !== e.y) begin
          $display("%0t pose_y exp %0d got %0d", $time, e.y, pose_y);
          errors++;
        end
        if (pose_heading !== e.hdg) begin
          $display("%0t pose_heading exp %0d got %0d", $time, e.hdg, pose_heading);
          errors++;
        end
        if (lateral_error !== e.lat) begin
          $display("%0t lateral_error exp %0d got %0d", $time, e.lat, lateral_error);
          errors++;
        end
        if (heading_error !== e.herr) begin
          $display("%0t heading_error exp %0d got %0d", $time, e.herr, heading_error);
          errors++;
        end
      end
    end
  end

  task automatic test_start_pose();
    write_reg(REG_START_X, 32'sd3 <<< 16);
    write_reg(REG_START_Y, -(32'sd2 <<< 16));
    write_reg(REG_START_H, 32'h0000_C000);
    write_reg(REG_RADIUS, 32'h0002_0000);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_command(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF);
    // start registers after the first item have no effect
    send_command(24'sd65536, 24'sd0, 24'd16384);
    wait_idle();
    write_reg(REG_START_X, 32'h7FFF_FFFF);
    write_reg(REG_START_Y, 32'h8000_0000);
    write_reg(REG_START_H, 32'h0000_FFFF);
    send_command(24'sd65536, 24'sd0, 24'd16384);
  endtask

  task automatic test_field_extremes();
    send_command(24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF);
    send_command(-24'sh800000, -24'sh800000, 24'hFFFFFF);
    send_command(24'sh7FFFFF, -24'sh800000, 24'd0);
    send_command(-24'sh800000, 24'sh7FFFFF, 24'd1);
    send_command(24'sh7FFFFF, 24'sd0, 24'hFFFFFF);
    send_command(24'sh7FFFFF, 24'sd0, 24'hFFFFFF);
    send_command(-24'sh800000, 24'sd102944, 24'hFFFFFF);
    send_command(24'sd0, 24'sd0, 24'd0);
    send_command(24'sd1, -24'sd1, 24'd1);
    send_command(-24'sd1, 24'sd1, 24'hFFFFFF);
    send_command(24'sh555555, 24'shAAAAAA, 24'hAAAAAA);
    send_command(24'shAAAAAA, 24'sh555555, 24'h555555);
  endtask

  task automatic test_origin_and_radius();
    // radius extremes: a zero and a small command with the largest radius, then radius zero
    wait_idle();
    write_reg(REG_RADIUS, 32'h7FFF_FFFF);
    send_command(24'sd0, 24'sd0, 24'd0);
    send_command(24'sd1000, 24'sd3000, 24'd200);
    wait_idle();
    write_reg(REG_RADIUS, 32'd0);
    for (int i = 0; i < 8; i++) send_random_command();
    wait_idle();
    write_reg(REG_RADIUS, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_random_command();
  endtask

  task automatic test_backpressure();
    wait_idle();
    stall_hold = 400;
    for (int i = 0; i < 20; i++) send_random_command();
    wait_idle();
  endtask

  task automatic test_random_commands();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        gaps_on = (i % 300 == 0);
        wait_idle();
        write_reg(REG_RADIUS, $urandom);
      end
      send_random_command();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 32'd0;
    in_valid = 1'b0;
    linear_velocity = 24'sd0;
    angular_velocity = 24'sd0;
    elapsed_time = 24'd0;
    radius_reg = 31'd65536;
    start_x_reg = 0;
    start_y_reg = 0;
    start_hdg_reg = 16'd0;
    robot_x = 0;
    robot_y = 0;
    robot_hdg = 16'd0;
    pose_loaded = 1'b0;
    errors = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    stall_hold = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_start_pose();
    test_field_extremes();
    test_origin_and_radius();
    test_backpressure();
    test_random_commands();
    wait_idle();

    if (errors == 0 && pending_poses.size() == 0) begin
      $display("[unicycle_pose_integrator_top] OK");
    end else begin
      $display("[unicycle_pose_integrator_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/upi_pkg.sv
sv/upi_cordic.sv
sv/unicycle_pose_integrator_top.sv
verif/testbench.sv
